[sv/bps_pkg.sv]
// Shared types, constants and helpers for the byte pattern search unit.
// No dependencies; used by the top level and by bps_window_match.
package bps_pkg;

  // Pattern window size and derived widths
  localparam int PAT_MAX   = 32;
  localparam int FILL_W    = $clog2(PAT_MAX + 1);
  localparam int SH_W      = (PAT_MAX > 1) ? $clog2(PAT_MAX) : 1;
  localparam int LEN_W     = 6;
  localparam int CFG_IDX_W = 3;
  localparam int NUM_WORDS = (PAT_MAX + 7) / 8;

  // ASCII case folding
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_OFFSET  = 8'd32;

  localparam logic [31:0] CNT_MAX     = 32'hFFFF_FFFF;
  localparam logic [15:0] HITS_RESET  = 16'd100;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAT_WORD0  = 3'd0,
    REG_PAT_WORD1  = 3'd1,
    REG_PAT_WORD2  = 3'd2,
    REG_PAT_WORD3  = 3'd3,
    REG_PAT_LENGTH = 3'd4,
    REG_CASE_INSEN = 3'd5,
    REG_MAX_HITS   = 3'd6
  } reg_idx_t;

  typedef logic [PAT_MAX-1:0][7:0] byte_vec_t;

  // Compare setup handed to the window matcher
  typedef struct packed {
    byte_vec_t          pat;      // folded pattern, entry i lines up with window entry i
    logic [PAT_MAX-1:0] mask;     // 1 for entries inside the pattern length
    logic               fold_en;
  } cmp_cfg_t;

  typedef struct packed {
    logic [63:0] match_address;
    logic [31:0] match_number;
    logic        recorded;
  } result_t;

  // Fold ASCII upper case to lower when enabled
  function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic en);
    logic [7:0] r;
    r = c;
    if (en && (c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z)) begin
      r = c + CASE_OFFSET;
    end
    return r;
  endfunction

endpackage

[sv/byte_pattern_search_unit.sv]
// Top level of the byte pattern search unit: config registers, byte window,
// counters and the result register with skid stage. Depends on bps_pkg, bps_window_match.
//
// Usage:
//   Input words (data byte, address, region-start flag) arrive on in_valid/in_stall,
//   one per cycle unless in_stall is high. Each accepted byte is shifted into a 32-entry
//   window and compared in parallel against the configured pattern; a hit gives one
//   result word (match address, running match number, recorded flag) on
//   out_valid/out_stall. Bytes that do not complete a match give no result.
//   A matching byte's result is registered in the output register or the skid buffer.
//   Throughput: one byte per cycle while in_stall is low; the window compare is a single
//   combinational pass. Stalls: a result held by out_stall stays in the output register;
//   the next result goes into a one-entry skid buffer, and in_stall is raised while that
//   buffer is occupied and after a configuration write or reset.
//   Configuration: cfg_valid/cfg_ready with a register index and 64-bit data. After a
//   write, in_stall is high for one cycle while the aligned pattern is rebuilt.
//   Reset (rst_n low, synchronous): counters, window fill, handshakes and registers
//   return to defaults (length 1, max hits 100); in_stall is high for the first cycle
//   after reset.
module byte_pattern_search_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_data_byte,
  input  logic [63:0]                   in_byte_address,
  input  logic                          in_region_start,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [63:0]                   out_match_address,
  output logic [31:0]                   out_match_number,
  output logic                          out_recorded,
  // configuration channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                   cfg_data
);

  // Configuration registers
  logic [bps_pkg::NUM_WORDS-1:0][63:0] pat_words_r;
  logic [bps_pkg::LEN_W-1:0]           pat_len_r;
  logic                                case_insen_r;
  logic [15:0]                         max_hits_r;
  logic                                cfg_ready_r;
  logic                                cfg_wr;

  // Derived compare setup
  bps_pkg::cmp_cfg_t                   cmp_cfg_r, cmp_cfg_nxt;
  logic [bps_pkg::FILL_W-1:0]          len_eff_r, len_eff_nxt;
  logic [bps_pkg::SH_W-1:0]            len_m1_r, len_m1_nxt;
  logic [15:0]                         limit_r, limit_nxt;
  logic                                pend_r;

  // Stream state
  bps_pkg::byte_vec_t                  wnd_r, wnd_nxt;
  logic [bps_pkg::FILL_W-1:0]          fill_r, fill_nxt;
  logic [31:0]                         cnt_r, cnt_nxt;

  // Output and skid
  bps_pkg::result_t                    out_r, out_nxt;
  bps_pkg::result_t                    skid_r, skid_nxt;
  bps_pkg::result_t                    res_new;
  logic                                out_valid_r, out_valid_nxt;
  logic                                skid_valid_r, skid_valid_nxt;

  logic                                accept;
  logic                                hit;
  logic                                found;
  logic                                out_free;
  logic [bps_pkg::FILL_W-1:0]          fill_base;
  logic [bps_pkg::FILL_W-1:0]          fill_inc;
  logic [bps_pkg::PAT_MAX*8-1:0]       pat_flat;
  bps_pkg::byte_vec_t                  pat_rev;
  bps_pkg::byte_vec_t                  pat_al;
  logic [bps_pkg::SH_W-1:0]            shift_bytes;

  assign cfg_ready = cfg_ready_r;
  assign cfg_wr    = cfg_valid & cfg_ready_r;

  // Configuration register writes; unused indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_words_r  <= '0;
      pat_len_r    <= bps_pkg::LEN_W'(1);
      case_insen_r <= 1'b0;
      max_hits_r   <= bps_pkg::HITS_RESET;
      cfg_ready_r  <= 1'b0;
    end else begin
      cfg_ready_r <= 1'b1;
      if (cfg_wr) begin
        unique case (bps_pkg::reg_idx_t'(cfg_index))
          bps_pkg::REG_PAT_WORD0:  pat_words_r[0] <= cfg_data;
          bps_pkg::REG_PAT_WORD1:  pat_words_r[1] <= cfg_data;
          bps_pkg::REG_PAT_WORD2:  pat_words_r[2] <= cfg_data;
          bps_pkg::REG_PAT_WORD3:  pat_words_r[3] <= cfg_data;
          bps_pkg::REG_PAT_LENGTH: pat_len_r      <= cfg_data[bps_pkg::LEN_W-1:0];
          bps_pkg::REG_CASE_INSEN: case_insen_r   <= cfg_data[0];
          bps_pkg::REG_MAX_HITS:   max_hits_r     <= cfg_data[15:0];
          default: ;
        endcase
      end
    end
  end

  // Effective length, hit limit and the pattern aligned to the window
  always_comb begin
    if (pat_len_r == '0) begin
      len_eff_nxt = bps_pkg::FILL_W'(1);
    end else if (pat_len_r > bps_pkg::LEN_W'(bps_pkg::PAT_MAX)) begin
      len_eff_nxt = bps_pkg::FILL_W'(bps_pkg::PAT_MAX);
    end else begin
      len_eff_nxt = bps_pkg::FILL_W'(pat_len_r);
    end
    len_m1_nxt  = bps_pkg::SH_W'(len_eff_nxt - bps_pkg::FILL_W'(1));
    shift_bytes = bps_pkg::SH_W'(bps_pkg::FILL_W'(bps_pkg::PAT_MAX) - len_eff_nxt);
    limit_nxt   = (max_hits_r == '0) ? 16'd1 : max_hits_r;

    // window entry i pairs with pattern byte len-1-i
    pat_flat = (bps_pkg::PAT_MAX*8)'(pat_words_r);
    for (int k = 0; k < bps_pkg::PAT_MAX; k++) begin
      pat_rev[k] = pat_flat[(bps_pkg::PAT_MAX-1-k)*8 +: 8];
    end
    pat_al = pat_rev >> {shift_bytes, 3'b000};

    for (int i = 0; i < bps_pkg::PAT_MAX; i++) begin
      cmp_cfg_nxt.mask[i] = (bps_pkg::FILL_W'(i) < len_eff_nxt);
      cmp_cfg_nxt.pat[i]  = bps_pkg::fold_byte(pat_al[i], case_insen_r);
    end
    cmp_cfg_nxt.fold_en = case_insen_r;
  end

  // Derived setup is registered from the configuration registers
  always_ff @(posedge clk) begin
    cmp_cfg_r <= cmp_cfg_nxt;
    len_eff_r <= len_eff_nxt;
    len_m1_r  <= len_m1_nxt;
    limit_r   <= limit_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b1;
    end else begin
      pend_r <= cfg_wr;
    end
  end

  // Input handshake
  assign in_stall = skid_valid_r | pend_r;
  assign accept   = in_valid & ~in_stall;

  // Window shift with the new byte at entry 0
  always_comb begin
    wnd_nxt[0] = in_data_byte;
    for (int k = 1; k < bps_pkg::PAT_MAX; k++) begin
      wnd_nxt[k] = wnd_r[k-1];
    end
  end

  bps_window_match u_match (
    .wnd (wnd_nxt),
    .cfg (cmp_cfg_r),
    .hit (hit)
  );

  // Fill count, match count and the new result
  always_comb begin
    fill_base = in_region_start ? '0 : fill_r;
    fill_inc  = (fill_base < bps_pkg::FILL_W'(bps_pkg::PAT_MAX)) ?
                fill_base + bps_pkg::FILL_W'(1) : fill_base;
    found     = accept & hit & (fill_inc >= len_eff_r);
    fill_nxt  = found ? '0 : fill_inc;
    cnt_nxt   = (found && cnt_r != bps_pkg::CNT_MAX) ? cnt_r + 32'd1 : cnt_r;

    res_new.match_address = in_byte_address - 64'(len_m1_r);
    res_new.match_number  = cnt_nxt;
    res_new.recorded      = (cnt_nxt <= 32'(limit_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      cnt_r  <= '0;
    end else if (accept) begin
      fill_r <= fill_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      wnd_r <= wnd_nxt;
    end
  end

  // Output register and skid buffer
  assign out_free = ~out_valid_r | ~out_stall;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_nxt        = out_r;
    skid_valid_nxt = skid_valid_r;
    skid_nxt       = skid_r;
    if (out_free) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_nxt        = skid_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = found;
        out_nxt       = res_new;
      end
    end else if (found) begin
      skid_valid_nxt = 1'b1;
      skid_nxt       = res_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_match_address = out_r.match_address;
  assign out_match_number  = out_r.match_number;
  assign out_recorded      = out_r.recorded;

endmodule

[sv/bps_window_match.sv]
// Parallel compare of the byte window against the aligned pattern.
// Depends on bps_pkg (types and fold_byte).
module bps_window_match (
  input  bps_pkg::byte_vec_t wnd,
  input  bps_pkg::cmp_cfg_t  cfg,
  output logic               hit
);

  logic [bps_pkg::PAT_MAX-1:0] eq;

  // One byte compare per window entry, entries past the length always pass
  always_comb begin
    for (int i = 0; i < bps_pkg::PAT_MAX; i++) begin
      eq[i] = (bps_pkg::fold_byte(wnd[i], cfg.fold_en) == cfg.pat[i]) | ~cfg.mask[i];
    end
  end

  assign hit = &eq;

endmodule

[sv/bps_port_monitor.sv]
// Port-level assertions for the byte pattern search unit, bound to the top level.
// Depends only on the top level's ports.
module bps_port_monitor (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] out_match_address,
  input logic [31:0] out_match_number,
  input logic        out_recorded,
  input logic        cfg_valid,
  input logic        cfg_ready
);

  // A stalled result word stays valid and unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_match_address) &&
      $stable(out_match_number) && $stable(out_recorded))
    else $error("result word dropped or changed while stalled");

  // Match numbers start at one
  a_num_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_match_number != 32'd0)
    else $error("match number zero");

  // The hit limit is 16 bits, so a recorded match has a small number
  a_rec_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_recorded |-> out_match_number[31:16] == 16'd0)
    else $error("recorded flag on a number above any hit limit");

  // Input is held off for the cycle after a configuration write
  a_cfg_block: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |=> in_stall)
    else $error("input open right after configuration write");

endmodule

bind byte_pattern_search_unit bps_port_monitor u_port_monitor (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_match_address (out_match_address),
  .out_match_number  (out_match_number),
  .out_recorded      (out_recorded),
  .cfg_valid         (cfg_valid),
  .cfg_ready         (cfg_ready)
);
